// ===== src/audio_matrix_mixer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the audio matrix mixer
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef AUDIO_MATRIX_MIXER_CORE_ASSERT_SVH
`define AUDIO_MATRIX_MIXER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AMM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("audio mixer port check failed");

// The consequent must hold in the cycle after the antecedent.
`define AMM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("audio mixer port check failed");

`endif

// ===== src/amm_pkg.sv =====
// ----------------------------------------------------------------------------
// Audio matrix mixer package
// Shared payload types, command codes and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package amm_pkg;

    // Channel fields are three bits wide, so at most eight rows and columns.
    localparam int CHAN_W      = 3;
    localparam int CHAN_LIMIT  = 8;
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = 32;
    localparam int ACC_W       = 40;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;

    localparam logic signed [COEF_W-1:0] UNITY_COEF = 16'sd4096;

    // Item commands.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS = 1'b1;

    typedef struct packed {
        logic                       cmd;
        logic [CHAN_W-1:0]          in_chan;
        logic [CHAN_W-1:0]          out_chan;
        logic signed [COEF_W-1:0]   coef;
        logic signed [SAMPLE_W-1:0] sample_re;
        logic signed [SAMPLE_W-1:0] sample_im;
        logic                       end_of_frame;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0]          mix_chan;
        logic signed [SAMPLE_W-1:0] mix_re;
        logic signed [SAMPLE_W-1:0] mix_im;
        logic                       clipped;
        logic                       last;
    } out_item_t;

    // Coefficient store write request.
    typedef struct packed {
        logic                     en;
        logic [CHAN_W-1:0]        row;
        logic [CHAN_W-1:0]        col;
        logic signed [COEF_W-1:0] data;
    } coef_wr_t;

    // Coefficient store read request.
    typedef struct packed {
        logic              en;
        logic [CHAN_W-1:0] row;
        logic [CHAN_W-1:0] col;
    } coef_rd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_EMIT
    } amm_state_t;

endpackage

`default_nettype wire

// ===== src/amm_coef_store.sv =====
// ----------------------------------------------------------------------------
// Coefficient store
// Mixing matrix memory with a registered read port. Entries never written
// read as the identity matrix through per-entry written flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module amm_coef_store #(
    parameter int ROWS = 8,
    parameter int COLS = 8
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire amm_pkg::coef_wr_t                wr,
    input  wire amm_pkg::coef_rd_t                rd,
    output logic signed [amm_pkg::COEF_W-1:0]     rd_coef
);
    import amm_pkg::*;

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [COEF_W-1:0] coef_mem_reg [DEPTH];
    logic [DEPTH-1:0]         written_reg;
    logic signed [COEF_W-1:0] rd_data_reg;
    logic                     rd_written_reg;
    logic                     rd_diag_reg;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;

    // Row-major addressing.
    assign wr_addr = AW'(int'(wr.row) * COLS + int'(wr.col));
    assign rd_addr = AW'(int'(rd.row) * COLS + int'(rd.col));

    // Memory write port.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            coef_mem_reg[wr_addr] <= wr.data;
        end
    end

    // Written flags, cleared by reset so the store reads as the identity.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (wr.en) begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg    <= coef_mem_reg[rd_addr];
            rd_written_reg <= written_reg[rd_addr];
            rd_diag_reg    <= (rd.row == rd.col);
        end
    end

    // An unwritten entry shows its reset value.
    always_comb begin
        if (rd_written_reg) begin
            rd_coef = rd_data_reg;
        end else if (rd_diag_reg) begin
            rd_coef = UNITY_COEF;
        end else begin
            rd_coef = '0;
        end
    end

endmodule

`default_nettype wire

// ===== src/audio_matrix_mixer_core.sv =====
// ----------------------------------------------------------------------------
// Audio matrix mixer core
// Mixes complex input channel samples into output channels through a
// coefficient matrix, one shared complex-by-real multiply-accumulate unit
// stepping over the output rows.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake            Payload
//   s_        in          s_valid / s_ready    in_item_t
//   m_        out         m_valid / m_ready    out_item_t
//   cfg_      in          cfg_we               cfg_idx, cfg_wdata
//
// A coefficient write goes straight into the store and s_ready stays high.
// A sample steps the N active output rows (N at most 8) through the memory
// read and MAC stages, or skips them.
// An end-of-frame sample then emits N output items and clears the
// accumulators; output stalls on m_ready hold up this output pass.
// Reset loads the identity matrix at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module audio_matrix_mixer_core #(
    parameter int MAX_IN_CHANNELS  = 8,
    parameter int MAX_OUT_CHANNELS = 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire amm_pkg::in_item_t                 s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output amm_pkg::out_item_t                     m_data,
    input  wire logic                              cfg_we,
    input  wire logic [amm_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  wire logic [amm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import amm_pkg::*;

    // Rows and columns reachable through the three-bit channel fields.
    localparam int ROWS   = (MAX_OUT_CHANNELS < CHAN_LIMIT) ? MAX_OUT_CHANNELS : CHAN_LIMIT;
    localparam int COLS   = (MAX_IN_CHANNELS < CHAN_LIMIT) ? MAX_IN_CHANNELS : CHAN_LIMIT;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Saturating 40-bit accumulate.
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [ACC_W:0] sum;
        sum = {acc[ACC_W-1], acc} + {{(ACC_W+1-PROD_W){prod[PROD_W-1]}}, prod};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            sat_add = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sat_add = sum[ACC_W-1:0];
        end
    endfunction

    // Round to nearest (ties up) from Q13.27 to Q1.15 and saturate.
    // The result holds the clip flag above the 16-bit value.
    function automatic logic [SAMPLE_W:0] to_q15(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0]    biased;
        logic signed [ACC_W-12:0] q;
        biased = {acc[ACC_W-1], acc} + (ACC_W+1)'(2048);
        q      = biased[ACC_W:12];
        if (q > (ACC_W-11)'(32767)) begin
            to_q15 = {1'b1, 16'h7FFF};
        end else if (q < -(ACC_W-11)'(32768)) begin
            to_q15 = {1'b1, 16'h8000};
        end else begin
            to_q15 = {1'b0, q[SAMPLE_W-1:0]};
        end
    endfunction

    amm_state_t                 state_reg, state_next;
    logic [CFG_DATA_W-1:0]      in_ch_reg;
    logic [CFG_DATA_W-1:0]      out_ch_reg;
    logic [CFG_DATA_W-1:0]      nout;

    logic [CHAN_W-1:0]          ichan_reg;
    logic signed [SAMPLE_W-1:0] sre_reg;
    logic signed [SAMPLE_W-1:0] sim_reg;
    logic                       eof_reg;
    logic                       mac_en_reg;

    logic [CFG_DATA_W-1:0]      issue_cnt_reg, issue_cnt_next;
    logic                       p1_vld_reg;
    logic [CHAN_W-1:0]          p1_row_reg;
    logic                       p2_vld_reg;
    logic [CHAN_W-1:0]          p2_row_reg;
    logic signed [PROD_W-1:0]   prod_re_reg;
    logic signed [PROD_W-1:0]   prod_im_reg;

    logic signed [ACC_W-1:0]    acc_re_reg [ROWS];
    logic signed [ACC_W-1:0]    acc_im_reg [ROWS];
    logic [ROW_AW-1:0]          acc_idx;
    logic signed [ACC_W-1:0]    acc_re_cur;
    logic signed [ACC_W-1:0]    acc_im_cur;

    logic [CFG_DATA_W-1:0]      emit_cnt_reg, emit_cnt_next;
    logic                       m_valid_reg, m_valid_next;
    out_item_t                  m_data_reg, m_data_next;

    logic                       s_accept;
    logic                       start_sample;
    logic                       sample_mac_en;
    logic                       acc_clear;
    logic                       emit_load;
    logic [SAMPLE_W:0]          q_re;
    logic [SAMPLE_W:0]          q_im;
    logic signed [COEF_W-1:0]   rd_coef;
    coef_wr_t                   coef_wr;
    coef_rd_t                   coef_rd;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Output rows in use this frame.
    assign nout = (out_ch_reg > CFG_DATA_W'(ROWS)) ? CFG_DATA_W'(ROWS) : out_ch_reg;

    // A sample is accumulated only on an input channel in use.
    assign sample_mac_en = ({1'b0, s_data.in_chan} < in_ch_reg) && (int'(s_data.in_chan) < COLS);
    assign start_sample  = s_accept && (s_data.cmd == CMD_SAMPLE);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ch_reg  <= CFG_DATA_W'(2);
            out_ch_reg <= CFG_DATA_W'(2);
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_IN_CHANNELS:  in_ch_reg  <= cfg_wdata;
                REG_OUT_CHANNELS: out_ch_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // Coefficient writes go straight into the store on transfer.
    always_comb begin
        coef_wr.en   = s_accept && (s_data.cmd == CMD_COEF) &&
                       (int'(s_data.in_chan) < COLS) && (int'(s_data.out_chan) < ROWS);
        coef_wr.row  = s_data.out_chan;
        coef_wr.col  = s_data.in_chan;
        coef_wr.data = s_data.coef;
    end

    // The row sequencer reads one weight of the sample's column per cycle.
    always_comb begin
        coef_rd.en  = (state_reg == ST_MAC) && mac_en_reg && (issue_cnt_reg < nout);
        coef_rd.row = issue_cnt_reg[CHAN_W-1:0];
        coef_rd.col = ichan_reg;
    end

    amm_coef_store #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_coef_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (coef_wr),
        .rd      (coef_rd),
        .rd_coef (rd_coef)
    );

    // One accumulator row is read per cycle, by the MAC or by the output pass.
    assign acc_idx    = (state_reg == ST_EMIT) ? emit_cnt_reg[ROW_AW-1:0] : p2_row_reg[ROW_AW-1:0];
    assign acc_re_cur = acc_re_reg[acc_idx];
    assign acc_im_cur = acc_im_reg[acc_idx];
    assign q_re       = to_q15(acc_re_cur);
    assign q_im       = to_q15(acc_im_cur);

    // Sequencer next state and control.
    always_comb begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        emit_cnt_next  = emit_cnt_reg;
        acc_clear      = 1'b0;
        emit_load      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                issue_cnt_next = '0;
                emit_cnt_next  = '0;
                if (start_sample) begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                if (coef_rd.en) begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end else if (!p1_vld_reg && !p2_vld_reg) begin
                    state_next = eof_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (emit_cnt_reg < nout) begin
                    if (!m_valid_reg || m_ready) begin
                        emit_load     = 1'b1;
                        emit_cnt_next = emit_cnt_reg + 1'b1;
                    end
                end else begin
                    acc_clear  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register next value.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit_load) begin
            m_valid_next         = 1'b1;
            m_data_next.mix_chan = emit_cnt_reg[CHAN_W-1:0];
            m_data_next.mix_re   = q_re[SAMPLE_W-1:0];
            m_data_next.mix_im   = q_im[SAMPLE_W-1:0];
            m_data_next.clipped  = q_re[SAMPLE_W] | q_im[SAMPLE_W];
            m_data_next.last     = ((emit_cnt_reg + 1'b1) == nout);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
            emit_cnt_reg  <= '0;
            p1_vld_reg    <= 1'b0;
            p2_vld_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            p1_vld_reg    <= coef_rd.en;
            p2_vld_reg    <= p1_vld_reg;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Sample capture, MAC pipeline payload and output payload.
    always_ff @(posedge aclk) begin
        if (start_sample) begin
            ichan_reg  <= s_data.in_chan;
            sre_reg    <= s_data.sample_re;
            sim_reg    <= s_data.sample_im;
            eof_reg    <= s_data.end_of_frame;
            mac_en_reg <= sample_mac_en;
        end
        p1_row_reg  <= coef_rd.row;
        p2_row_reg  <= p1_row_reg;
        prod_re_reg <= sre_reg * rd_coef;
        prod_im_reg <= sim_reg * rd_coef;
        m_data_reg  <= m_data_next;
    end

    // Accumulators: saturating add from the product stage, cleared after output.
    always_ff @(posedge aclk) begin
        if (!aresetn || acc_clear) begin
            for (int r = 0; r < ROWS; r++) begin
                acc_re_reg[r] <= '0;
                acc_im_reg[r] <= '0;
            end
        end else if (p2_vld_reg) begin
            acc_re_reg[acc_idx] <= sat_add(acc_re_cur, prod_re_reg);
            acc_im_reg[acc_idx] <= sat_add(acc_im_cur, prod_im_reg);
        end
    end

endmodule

`default_nettype wire

// ===== src/amm_checker.sv =====
// ----------------------------------------------------------------------------
// Audio matrix mixer port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "audio_matrix_mixer_core_assert.svh"

module amm_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire amm_pkg::in_item_t   s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire amm_pkg::out_item_t  m_data
);
    import amm_pkg::*;

    // A stalled result holds still.
    `AMM_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // A sample transfer starts the row pass, so the input side closes.
    `AMM_ASSERT_NEXT(a_sample_busy, s_valid && s_ready && (s_data.cmd == CMD_SAMPLE), !s_ready)

    // A coefficient write never produces a result.
    `AMM_ASSERT_NEXT(a_coef_quiet, s_valid && s_ready && (s_data.cmd == CMD_COEF) && !m_valid,
        !m_valid)

    // While a frame's results are still coming out, no input is taken.
    `AMM_ASSERT_NOW(a_frame_busy, m_valid && !m_data.last, !s_ready)

endmodule

bind audio_matrix_mixer_core amm_checker u_amm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
